FILE: design/stt_pkg.sv
package stt_pkg;

	localparam int LINE_BITS = 20;
	localparam int COLUMN_BITS = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_EXP_LO = 8'h65;
	localparam logic [7:0] CH_EXP_HI = 8'h45;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic [2:0] KIND_BLANK = 3'd0;
	localparam logic [2:0] KIND_IDENT = 3'd1;
	localparam logic [2:0] KIND_STRING = 3'd2;
	localparam logic [2:0] KIND_NUMBER = 3'd3;
	localparam logic [2:0] KIND_BRACKET = 3'd4;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_UNKNOWN = 2'd1,
		ERR_NUMBER = 2'd2,
		ERR_OPEN_END = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_IDENT = 3'd2,
		MODE_STRING = 3'd3,
		MODE_NUMBER = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		NS_START = 3'd0,
		NS_LEAD_DOT = 3'd1,
		NS_INT = 3'd2,
		NS_FRAC = 3'd3,
		NS_EXP = 3'd4,
		NS_EXP_SIGN = 3'd5,
		NS_EXP_DIGIT = 3'd6,
		NS_SIGN = 3'd7
	} num_state_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic [2:0] token_kind;
		logic token_start;
		logic in_text;
		logic closes_stream;
		logic [1:0] error_code;
		logic [LINE_BITS-1:0] line_number;
		logic [COLUMN_BITS-1:0] column_number;
	} out_word_t;

	typedef struct packed {
		logic blank;
		logic newline;
		logic hash;
		logic alpha;
		logic quote;
		logic digit;
		logic sign;
		logic dot;
		logic expo;
		logic bracket;
	} char_class_t;

	typedef struct packed {
		in_word_t word;
		char_class_t cls;
	} item_t;

	typedef struct packed {
		logic ok;
		num_state_t state;
		logic pt;
	} num_step_t;

	function automatic num_step_t num_next(num_state_t st, char_class_t cl, logic pt);
		num_step_t r;
		r.ok = 1'b1;
		r.state = st;
		r.pt = pt;
		case (st)
			NS_START: begin
				if (cl.dot) begin
					r.pt = 1'b1;
					r.state = NS_LEAD_DOT;
				end else if (cl.sign) begin
					r.state = NS_SIGN;
				end else if (cl.digit) begin
					r.state = NS_INT;
				end else begin
					r.ok = 1'b0;
				end
			end
			NS_LEAD_DOT: begin
				if (cl.digit) begin
					r.state = pt ? NS_FRAC : NS_INT;
				end else begin
					r.ok = 1'b0;
				end
			end
			NS_INT: begin
				if (cl.dot && !pt) begin
					r.pt = 1'b1;
					r.state = NS_FRAC;
				end else if (cl.digit) begin
					r.state = NS_INT;
				end else if (cl.expo) begin
					r.state = NS_EXP;
				end else begin
					r.ok = 1'b0;
				end
			end
			NS_FRAC: begin
				if (cl.digit) begin
					r.state = NS_FRAC;
				end else if (cl.expo) begin
					r.state = NS_EXP;
				end else begin
					r.ok = 1'b0;
				end
			end
			NS_EXP: begin
				if (cl.sign) begin
					r.state = NS_EXP_SIGN;
				end else if (cl.digit) begin
					r.state = NS_EXP_DIGIT;
				end else begin
					r.ok = 1'b0;
				end
			end
			NS_EXP_SIGN, NS_EXP_DIGIT: begin
				if (cl.digit) begin
					r.state = NS_EXP_DIGIT;
				end else begin
					r.ok = 1'b0;
				end
			end
			NS_SIGN: begin
				if (cl.digit) begin
					r.state = NS_INT;
				end else if (cl.dot) begin
					r.pt = 1'b1;
					r.state = NS_LEAD_DOT;
				end else begin
					r.ok = 1'b0;
				end
			end
			default: begin
				r.ok = 1'b0;
			end
		endcase
		return r;
	endfunction

	function automatic logic num_accepting(num_state_t st);
		return (st == NS_INT) || (st == NS_FRAC) || (st == NS_EXP_DIGIT);
	endfunction

endpackage

FILE: design/scene_text_tokenizer.sv
// Channel   Direction  Word type              Handshake
// byte      in         stt_pkg::in_word_t     byte_valid / byte_stall
// label     out        stt_pkg::out_word_t    label_valid / label_stall
//
// One byte is taken every clock while the queue is not full, and one label word leaves for each byte.
// A byte passes through the four-entry queue and then through the output register
// after the scanner state machine.
// The byte side stalls only when the queue is full; the label side stall
// holds the output register and lets the queue fill behind it.
// Reset clears the queue, the scanner state and the sticky error.
module scene_text_tokenizer (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_stall,
	input stt_pkg::in_word_t byte_word,
	output logic label_valid,
	input logic label_stall,
	output stt_pkg::out_word_t label_word
);

	stt_pkg::item_t front_item;
	stt_pkg::item_t head;
	logic full;
	logic not_empty;
	logic pop;
	logic push;

	assign byte_stall = full;
	assign push = byte_valid && !full;

	stt_front u_front (
		.word(byte_word),
		.item(front_item)
	);

	stt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(front_item),
		.full(full),
		.pop(pop),
		.not_empty(not_empty),
		.head(head)
	);

	stt_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(not_empty),
		.item(head),
		.item_pop(pop),
		.label_valid(label_valid),
		.label_stall(label_stall),
		.label_word(label_word)
	);

endmodule

FILE: design/stt_front.sv
module stt_front (
	input stt_pkg::in_word_t word,
	output stt_pkg::item_t item
);

	stt_pkg::char_class_t cls;

	always_comb begin
		logic [7:0] c;
		c = word.char_code;
		cls = '0;
		cls.newline = (c == stt_pkg::CH_LF);
		cls.blank = (c == stt_pkg::CH_SPACE) || (c == stt_pkg::CH_TAB) ||
			(c == stt_pkg::CH_CR) || (c == stt_pkg::CH_LF);
		cls.hash = (c == stt_pkg::CH_HASH);
		cls.alpha = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
		cls.quote = (c == stt_pkg::CH_QUOTE);
		cls.digit = c inside {[8'h30:8'h39]};
		cls.sign = (c == stt_pkg::CH_PLUS) || (c == stt_pkg::CH_MINUS);
		cls.dot = (c == stt_pkg::CH_DOT);
		cls.expo = (c == stt_pkg::CH_EXP_LO) || (c == stt_pkg::CH_EXP_HI);
		cls.bracket = (c == stt_pkg::CH_LBRACKET) || (c == stt_pkg::CH_RBRACKET);
	end

	assign item.word = word;
	assign item.cls = cls;

endmodule

FILE: design/stt_queue.sv
module stt_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input stt_pkg::item_t push_item,
	output logic full,
	input logic pop,
	output logic not_empty,
	output stt_pkg::item_t head
);

	localparam int PB = stt_pkg::QPTR_BITS;

	stt_pkg::item_t mem_q [stt_pkg::QUEUE_DEPTH];
	logic [PB-1:0] wr_ptr_q;
	logic [PB-1:0] rd_ptr_q;
	logic [PB:0] count_q;

	assign full = (count_q == (PB+1)'(stt_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/stt_back.sv
module stt_back (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input stt_pkg::item_t item,
	output logic item_pop,
	output logic label_valid,
	input logic label_stall,
	output stt_pkg::out_word_t label_word
);

	localparam int LB = stt_pkg::LINE_BITS;
	localparam int CB = stt_pkg::COLUMN_BITS;

	stt_pkg::mode_t mode_q, mode_n;
	stt_pkg::num_state_t ns_q, ns_n;
	logic pt_q, pt_n;
	logic [LB-1:0] line_q, line_n;
	logic [CB-1:0] col_q, col_n;
	stt_pkg::err_t err_q, err_n;
	stt_pkg::out_word_t res;
	stt_pkg::out_word_t out_q;
	logic out_valid_q;
	logic load;

	assign load = item_valid && (!out_valid_q || !label_stall);
	assign item_pop = load;
	assign label_valid = out_valid_q;
	assign label_word = out_q;

	always_comb begin
		logic redo;
		stt_pkg::err_t newerr;
		stt_pkg::num_step_t step;
		stt_pkg::num_step_t first;
		stt_pkg::char_class_t cl;
		logic [CB-1:0] col;

		cl = item.cls;
		redo = 1'b0;
		newerr = stt_pkg::ERR_NONE;
		mode_n = mode_q;
		ns_n = ns_q;
		pt_n = pt_q;
		err_n = err_q;
		col = (col_q == '1) ? col_q : col_q + 1'b1;
		step = stt_pkg::num_next(ns_q, cl, pt_q);
		first = stt_pkg::num_next(stt_pkg::NS_START, cl, 1'b0);

		res.out_char = item.word.char_code;
		res.token_kind = stt_pkg::KIND_BLANK;
		res.token_start = 1'b0;
		res.in_text = 1'b0;
		res.closes_stream = item.word.end_of_text;
		res.line_number = line_q;
		res.column_number = col;

		if (err_q == stt_pkg::ERR_NONE) begin
			case (mode_q)
				stt_pkg::MODE_COMMENT: begin
					if (cl.newline) begin
						mode_n = stt_pkg::MODE_IDLE;
					end
				end
				stt_pkg::MODE_IDENT: begin
					if (cl.alpha) begin
						res.token_kind = stt_pkg::KIND_IDENT;
						res.in_text = 1'b1;
					end else begin
						redo = 1'b1;
					end
				end
				stt_pkg::MODE_STRING: begin
					res.token_kind = stt_pkg::KIND_STRING;
					if (cl.quote) begin
						mode_n = stt_pkg::MODE_IDLE;
					end else begin
						res.in_text = 1'b1;
					end
				end
				stt_pkg::MODE_NUMBER: begin
					if (step.ok) begin
						ns_n = step.state;
						pt_n = step.pt;
						res.token_kind = stt_pkg::KIND_NUMBER;
						res.in_text = 1'b1;
					end else if (stt_pkg::num_accepting(ns_q)) begin
						redo = 1'b1;
					end else begin
						newerr = stt_pkg::ERR_NUMBER;
					end
				end
				default: begin
					redo = 1'b1;
				end
			endcase

			// A byte that ends an identifier or number, or arrives while idle, starts the next token.
			if (redo) begin
				mode_n = stt_pkg::MODE_IDLE;
				if (cl.blank) begin
					mode_n = stt_pkg::MODE_IDLE;
				end else if (cl.hash) begin
					mode_n = stt_pkg::MODE_COMMENT;
				end else if (cl.alpha) begin
					mode_n = stt_pkg::MODE_IDENT;
					res.token_kind = stt_pkg::KIND_IDENT;
					res.token_start = 1'b1;
					res.in_text = 1'b1;
				end else if (cl.quote) begin
					mode_n = stt_pkg::MODE_STRING;
					res.token_kind = stt_pkg::KIND_STRING;
					res.token_start = 1'b1;
				end else if (cl.sign || cl.dot || cl.digit) begin
					mode_n = stt_pkg::MODE_NUMBER;
					ns_n = first.state;
					pt_n = first.pt;
					res.token_kind = stt_pkg::KIND_NUMBER;
					res.token_start = 1'b1;
					res.in_text = 1'b1;
				end else if (cl.bracket) begin
					res.token_kind = stt_pkg::KIND_BRACKET;
					res.token_start = 1'b1;
					res.in_text = 1'b1;
				end else begin
					newerr = stt_pkg::ERR_UNKNOWN;
				end
			end

			if (newerr != stt_pkg::ERR_NONE) begin
				err_n = newerr;
				res.token_kind = stt_pkg::KIND_BLANK;
				res.token_start = 1'b0;
				res.in_text = 1'b0;
				mode_n = stt_pkg::MODE_IDLE;
			end else if (item.word.end_of_text) begin
				if ((mode_n == stt_pkg::MODE_STRING) ||
					((mode_n == stt_pkg::MODE_NUMBER) && !stt_pkg::num_accepting(ns_n))) begin
					err_n = stt_pkg::ERR_OPEN_END;
				end
			end
		end

		res.error_code = err_n;

		line_n = line_q;
		col_n = col;
		if (cl.newline) begin
			line_n = (line_q == '1) ? line_q : line_q + 1'b1;
			col_n = '0;
		end
		if (item.word.end_of_text) begin
			mode_n = stt_pkg::MODE_IDLE;
			ns_n = stt_pkg::NS_START;
			pt_n = 1'b0;
			line_n = LB'(1);
			col_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::MODE_IDLE;
			ns_q <= stt_pkg::NS_START;
			pt_q <= 1'b0;
			line_q <= LB'(1);
			col_q <= '0;
			err_q <= stt_pkg::ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mode_q <= mode_n;
				ns_q <= ns_n;
				pt_q <= pt_n;
				line_q <= line_n;
				col_q <= col_n;
				err_q <= err_n;
				out_valid_q <= 1'b1;
			end else if (!label_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int LB = stt_pkg::LINE_BITS;

	typedef struct {
		stt_pkg::mode_t mode;
		stt_pkg::num_state_t ns;
		bit pt;
		logic [stt_pkg::LINE_BITS-1:0] line;
		logic [stt_pkg::COLUMN_BITS-1:0] col;
		stt_pkg::err_t err;
	} scan_t;

	class label_scoreboard;
		scan_t st;
		stt_pkg::out_word_t pending_labels[$];
		int mismatches;
		int labels_checked;

		function new();
			st.mode = stt_pkg::MODE_IDLE;
			st.ns = stt_pkg::NS_START;
			st.pt = 1'b0;
			st.line = LB'(1);
			st.col = '0;
			st.err = stt_pkg::ERR_NONE;
			mismatches = 0;
			labels_checked = 0;
		endfunction

		function bit is_letter(logic [7:0] c);
			return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= 8'h30 && c <= 8'h39;
		endfunction

		function bit accepting(stt_pkg::num_state_t ns);
			return ns == stt_pkg::NS_INT || ns == stt_pkg::NS_FRAC ||
				ns == stt_pkg::NS_EXP_DIGIT;
		endfunction

		function bit number_step(stt_pkg::num_state_t cur, logic [7:0] c, inout bit pt,
			output stt_pkg::num_state_t nxt);
			bit dg;
			bit sg;
			bit dot;
			bit ex;
			dg = is_digit(c);
			sg = c == stt_pkg::CH_PLUS || c == stt_pkg::CH_MINUS;
			dot = c == stt_pkg::CH_DOT;
			ex = c == stt_pkg::CH_EXP_LO || c == stt_pkg::CH_EXP_HI;
			nxt = cur;
			case (cur)
				stt_pkg::NS_START: begin
					if (dot) begin
						pt = 1'b1;
						nxt = stt_pkg::NS_LEAD_DOT;
					end else if (sg) begin
						nxt = stt_pkg::NS_SIGN;
					end else if (dg) begin
						nxt = stt_pkg::NS_INT;
					end else begin
						return 1'b0;
					end
				end
				stt_pkg::NS_LEAD_DOT: begin
					if (!dg)
						return 1'b0;
					nxt = pt ? stt_pkg::NS_FRAC : stt_pkg::NS_INT;
				end
				stt_pkg::NS_INT: begin
					if (dot && !pt) begin
						pt = 1'b1;
						nxt = stt_pkg::NS_FRAC;
					end else if (dg) begin
						nxt = stt_pkg::NS_INT;
					end else if (ex) begin
						nxt = stt_pkg::NS_EXP;
					end else begin
						return 1'b0;
					end
				end
				stt_pkg::NS_FRAC: begin
					if (dg) begin
						nxt = stt_pkg::NS_FRAC;
					end else if (ex) begin
						nxt = stt_pkg::NS_EXP;
					end else begin
						return 1'b0;
					end
				end
				stt_pkg::NS_EXP: begin
					if (sg) begin
						nxt = stt_pkg::NS_EXP_SIGN;
					end else if (dg) begin
						nxt = stt_pkg::NS_EXP_DIGIT;
					end else begin
						return 1'b0;
					end
				end
				stt_pkg::NS_EXP_SIGN, stt_pkg::NS_EXP_DIGIT: begin
					if (!dg)
						return 1'b0;
					nxt = stt_pkg::NS_EXP_DIGIT;
				end
				stt_pkg::NS_SIGN: begin
					if (dg) begin
						nxt = stt_pkg::NS_INT;
					end else if (dot) begin
						pt = 1'b1;
						nxt = stt_pkg::NS_LEAD_DOT;
					end else begin
						return 1'b0;
					end
				end
				default: begin
					return 1'b0;
				end
			endcase
			return 1'b1;
		endfunction

		// Opens whatever the byte begins when no token is holding it.
		function stt_pkg::err_t start_token(inout scan_t s, input logic [7:0] c,
			inout stt_pkg::out_word_t o);
			stt_pkg::num_state_t nxt;
			bit pt;
			o.token_kind = stt_pkg::KIND_BLANK;
			o.token_start = 1'b0;
			o.in_text = 1'b0;
			s.mode = stt_pkg::MODE_IDLE;
			if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_TAB || c == stt_pkg::CH_CR ||
				c == stt_pkg::CH_LF)
				return stt_pkg::ERR_NONE;
			if (c == stt_pkg::CH_HASH) begin
				s.mode = stt_pkg::MODE_COMMENT;
				return stt_pkg::ERR_NONE;
			end
			if (is_letter(c)) begin
				s.mode = stt_pkg::MODE_IDENT;
				o.token_kind = stt_pkg::KIND_IDENT;
				o.token_start = 1'b1;
				o.in_text = 1'b1;
				return stt_pkg::ERR_NONE;
			end
			if (c == stt_pkg::CH_QUOTE) begin
				s.mode = stt_pkg::MODE_STRING;
				o.token_kind = stt_pkg::KIND_STRING;
				o.token_start = 1'b1;
				return stt_pkg::ERR_NONE;
			end
			if (is_digit(c) || c == stt_pkg::CH_PLUS || c == stt_pkg::CH_MINUS ||
				c == stt_pkg::CH_DOT) begin
				pt = 1'b0;
				void'(number_step(stt_pkg::NS_START, c, pt, nxt));
				s.ns = nxt;
				s.pt = pt;
				s.mode = stt_pkg::MODE_NUMBER;
				o.token_kind = stt_pkg::KIND_NUMBER;
				o.token_start = 1'b1;
				o.in_text = 1'b1;
				return stt_pkg::ERR_NONE;
			end
			if (c == stt_pkg::CH_LBRACKET || c == stt_pkg::CH_RBRACKET) begin
				o.token_kind = stt_pkg::KIND_BRACKET;
				o.token_start = 1'b1;
				o.in_text = 1'b1;
				return stt_pkg::ERR_NONE;
			end
			return stt_pkg::ERR_UNKNOWN;
		endfunction

		function stt_pkg::out_word_t label(inout scan_t s, input stt_pkg::in_word_t w);
			stt_pkg::out_word_t o;
			logic [7:0] c;
			bit redo;
			bit pt;
			stt_pkg::err_t raised;
			stt_pkg::num_state_t nxt;
			c = w.char_code;
			o = '0;
			o.out_char = c;
			o.closes_stream = w.end_of_text;
			redo = 1'b0;
			raised = stt_pkg::ERR_NONE;
			if (s.col != '1)
				s.col = s.col + 1'b1;
			o.line_number = s.line;
			o.column_number = s.col;
			if (s.err == stt_pkg::ERR_NONE) begin
				case (s.mode)
					stt_pkg::MODE_COMMENT: begin
						if (c == stt_pkg::CH_LF)
							s.mode = stt_pkg::MODE_IDLE;
					end
					stt_pkg::MODE_IDENT: begin
						if (is_letter(c)) begin
							o.token_kind = stt_pkg::KIND_IDENT;
							o.in_text = 1'b1;
						end else begin
							redo = 1'b1;
						end
					end
					stt_pkg::MODE_STRING: begin
						o.token_kind = stt_pkg::KIND_STRING;
						if (c == stt_pkg::CH_QUOTE)
							s.mode = stt_pkg::MODE_IDLE;
						else
							o.in_text = 1'b1;
					end
					stt_pkg::MODE_NUMBER: begin
						pt = s.pt;
						if (number_step(s.ns, c, pt, nxt)) begin
							s.ns = nxt;
							s.pt = pt;
							o.token_kind = stt_pkg::KIND_NUMBER;
							o.in_text = 1'b1;
						end else if (accepting(s.ns)) begin
							redo = 1'b1;
						end else begin
							raised = stt_pkg::ERR_NUMBER;
						end
					end
					default: begin
						redo = 1'b1;
					end
				endcase
				if (redo)
					raised = start_token(s, c, o);
				if (raised != stt_pkg::ERR_NONE) begin
					s.err = raised;
					o.token_kind = stt_pkg::KIND_BLANK;
					o.token_start = 1'b0;
					o.in_text = 1'b0;
					s.mode = stt_pkg::MODE_IDLE;
				end else if (w.end_of_text && (s.mode == stt_pkg::MODE_STRING ||
					(s.mode == stt_pkg::MODE_NUMBER && !accepting(s.ns)))) begin
					s.err = stt_pkg::ERR_OPEN_END;
				end
			end
			if (c == stt_pkg::CH_LF) begin
				if (s.line != '1)
					s.line = s.line + 1'b1;
				s.col = '0;
			end
			if (w.end_of_text) begin
				s.mode = stt_pkg::MODE_IDLE;
				s.ns = stt_pkg::NS_START;
				s.pt = 1'b0;
				s.line = LB'(1);
				s.col = '0;
			end
			o.error_code = s.err;
			return o;
		endfunction

		function bit would_fail(stt_pkg::in_word_t w);
			scan_t trial;
			stt_pkg::out_word_t ignored;
			trial = st;
			ignored = label(trial, w);
			return trial.err != st.err;
		endfunction

		function void note_byte(stt_pkg::in_word_t w);
			pending_labels.push_back(label(st, w));
		endfunction

		function void compare_field(string field, longint unsigned want,
			longint unsigned got);
			if (want == got)
				return;
			mismatches++;
			if (mismatches <= 10)
				$display("label %0d: %s expected %0h, got %0h", labels_checked, field, want, got);
		endfunction

		function void check_label(stt_pkg::out_word_t got);
			stt_pkg::out_word_t want;
			labels_checked++;
			if (pending_labels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("label %0d arrived with no byte pending: %0h", labels_checked, got);
				return;
			end
			want = pending_labels.pop_front();
			compare_field("out_char", want.out_char, got.out_char);
			compare_field("token_kind", want.token_kind, got.token_kind);
			compare_field("token_start", want.token_start, got.token_start);
			compare_field("in_text", want.in_text, got.in_text);
			compare_field("closes_stream", want.closes_stream, got.closes_stream);
			compare_field("error_code", want.error_code, got.error_code);
			compare_field("line_number", want.line_number, got.line_number);
			compare_field("column_number", want.column_number, got.column_number);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	stt_pkg::in_word_t byte_word = '0;
	logic label_valid;
	logic label_stall = 1'b0;
	stt_pkg::out_word_t label_word;

	label_scoreboard sb = new();
	bit gaps_on = 1'b1;
	int random_sent = 0;
	logic [7:0] blanks [4] = '{stt_pkg::CH_SPACE, stt_pkg::CH_TAB, stt_pkg::CH_CR,
		stt_pkg::CH_LF};
	string broken_numbers [4] = '{"-", ".", "7e", "7e+"};

	scene_text_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_word(byte_word),
		.label_valid(label_valid),
		.label_stall(label_stall),
		.label_word(label_word)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit roll_gap();
		return gaps_on && ($urandom_range(99) < 8);
	endfunction

	function automatic logic [7:0] digit();
		return 8'h30 + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] any_byte_but(logic [7:0] barred);
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c == barred);
		return c;
	endfunction

	task automatic send_char(input logic [7:0] c, input bit eot);
		stt_pkg::in_word_t w;
		w.char_code = c;
		w.end_of_text = eot;
		while (roll_gap()) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_word <= w;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		sb.note_byte(w);
	endtask

	task automatic send_str(input string s, input bit eot_last);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], eot_last && (i == s.len() - 1));
	endtask

	// Keeps the text free of errors so that the sticky error is saved for the end.
	task automatic send_clean(input logic [7:0] c, input bit eot);
		stt_pkg::in_word_t w;
		w.char_code = c;
		w.end_of_text = eot;
		if (sb.would_fail(w))
			w.end_of_text = 1'b0;
		if (sb.would_fail(w))
			w.char_code = stt_pkg::CH_SPACE;
		if (sb.would_fail(w))
			w.char_code = 8'h30;
		send_char(w.char_code, w.end_of_text);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			label_stall <= 1'b0;
		else
			label_stall <= roll_gap();
	end

	always @(posedge clk) begin
		if (arst_n && label_valid && !label_stall)
			sb.check_label(label_word);
	end

	initial begin
		logic [7:0] q[$];
		int pick;
		int shape;
		stt_pkg::err_t planned;
		stt_pkg::in_word_t w;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_char(stt_pkg::CH_HASH, 1'b0);
		send_char(8'hFF, 1'b0);
		send_str("\nab\"", 1'b0);
		send_char(8'h80, 1'b0);
		send_char(8'h00, 1'b0);
		send_str("z\"-1.5e-3][.5\t", 1'b0);
		send_char(stt_pkg::CH_CR, 1'b0);
		send_str("+7E2", 1'b1);
		send_str("q", 1'b1);

		while (random_sent < 885) begin
			gaps_on = !(random_sent inside {[300:499]});
			q.delete();
			pick = $urandom_range(99);
			if (pick < 12) begin
				repeat ($urandom_range(1, 3)) q.push_back(blanks[$urandom_range(3)]);
			end else if (pick < 20) begin
				q.push_back(stt_pkg::CH_HASH);
				repeat ($urandom_range(8)) q.push_back(any_byte_but(stt_pkg::CH_LF));
				q.push_back(stt_pkg::CH_LF);
			end else if (pick < 35) begin
				repeat ($urandom_range(1, 8))
					q.push_back(($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25)));
			end else if (pick < 47) begin
				q.push_back(stt_pkg::CH_QUOTE);
				repeat ($urandom_range(8)) q.push_back(any_byte_but(stt_pkg::CH_QUOTE));
				q.push_back(stt_pkg::CH_QUOTE);
			end else if (pick < 72) begin
				if ($urandom_range(2) == 0)
					q.push_back($urandom_range(1) ? stt_pkg::CH_PLUS : stt_pkg::CH_MINUS);
				shape = $urandom_range(2);
				if (shape != 2)
					repeat ($urandom_range(1, 4)) q.push_back(digit());
				if (shape != 0) begin
					q.push_back(stt_pkg::CH_DOT);
					repeat ($urandom_range(shape == 2 ? 1 : 0, 3)) q.push_back(digit());
				end
				if ($urandom_range(3) == 0) begin
					q.push_back($urandom_range(1) ? stt_pkg::CH_EXP_LO : stt_pkg::CH_EXP_HI);
					if ($urandom_range(1))
						q.push_back($urandom_range(1) ? stt_pkg::CH_PLUS : stt_pkg::CH_MINUS);
					repeat ($urandom_range(1, 3)) q.push_back(digit());
				end
			end else if (pick < 82) begin
				q.push_back($urandom_range(1) ? stt_pkg::CH_LBRACKET : stt_pkg::CH_RBRACKET);
			end else if (pick < 92) begin
				q.push_back(8'($urandom_range(255)));
			end else begin
				if ($urandom_range(1)) begin
					q.push_back(digit());
					q.push_back($urandom_range(1) ? stt_pkg::CH_EXP_LO : stt_pkg::CH_EXP_HI);
				end else begin
					q.push_back($urandom_range(1) ? stt_pkg::CH_DOT : stt_pkg::CH_MINUS);
				end
				q.push_back(8'($urandom_range(255)));
			end
			foreach (q[i])
				send_clean(q[i], $urandom_range(99) < 3);
			random_sent += q.size();
		end

		gaps_on = 1'b1;
		if (sb.st.mode == stt_pkg::MODE_STRING)
			send_char(stt_pkg::CH_QUOTE, 1'b0);
		send_char(8'h30, 1'b0);
		send_char(stt_pkg::CH_LF, 1'b1);

		planned = stt_pkg::err_t'($urandom_range(1, 3));
		case (planned)
			stt_pkg::ERR_UNKNOWN: begin
				w.end_of_text = 1'b0;
				do
					w.char_code = 8'($urandom_range(255));
				while (!sb.would_fail(w));
				send_char(w.char_code, 1'b0);
			end
			stt_pkg::ERR_NUMBER: begin
				send_str(broken_numbers[$urandom_range(3)], 1'b0);
				send_char(stt_pkg::CH_SPACE, 1'($urandom_range(1)));
			end
			default: begin
				if ($urandom_range(1))
					send_str("\"ab", 1'b1);
				else
					send_str("4e", 1'b1);
			end
		endcase
		repeat (30) send_char(8'($urandom_range(255)), $urandom_range(9) == 0);
		byte_valid <= 1'b0;

		while (sb.pending_labels.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0)
			$display("scene_text_tokenizer regression: pass");
		else
			$display("scene_text_tokenizer regression: fail");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("scene_text_tokenizer regression: fail");
		$finish;
	end

endmodule
